>>> design/g2em_pkg.sv
// Shared constants for the 2x2 gradient edge magnitude block.
`default_nettype none
package g2em_pkg;

   // Field and register widths.
   localparam int PIXEL_W = 8;
   localparam int DIM_W   = 13;
   localparam int ROW_W   = 12;

   // Line store depth default and the fixed frame height limit.
   localparam int MAX_WIDTH_DEFAULT = 4096;
   localparam int MAX_HEIGHT        = 4096;

   // Sum of squares and root widths (sum of squares stays below 2**20).
   localparam int SQ_W   = 20;
   localparam int ROOT_W = SQ_W / 2;
   localparam int GRAD_W = PIXEL_W + 3;
   localparam int PROD_W = 2 * GRAD_W;

   // Output saturation limit.
   localparam logic [PIXEL_W-1:0] SAT_LIMIT = 8'd255;

   // Register reset values.
   localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

   // Register indexes.
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

endpackage
`default_nettype wire

>>> design/gradient_2x2_edge_magnitude.sv
// Top level of the 2x2 gradient edge magnitude block.
//
//   Channel   Direction   Handshake                 Payload
//   req       in          req_valid / req_stall     req_pixel
//   rsp       out         rsp_valid / rsp_stall     rsp_edge_magnitude, rsp_row_end,
//                                                   rsp_frame_end
//   csr       in          csr_write_enable          csr_index, csr_write_data
//
// A request that completes a 2x2 window goes from acceptance to the next acceptance through
// one line store read, the squaring of gx and gy on a shared multiplier, the bit-serial
// square root, the load of the output register and the idle state that takes the next
// request. A request on the first row or column passes only through the line store read.
// A finished result waits in the output register while the next request is processed;
// a stalled output register holds the next result in the square root wait.
// Reset is synchronous and clears the counters, window registers and handshake state; the
// line store is not cleared and is read at the current column on every accepted request.
`default_nettype none
module gradient_2x2_edge_magnitude #(
   parameter int MAX_WIDTH = g2em_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [g2em_pkg::PIXEL_W-1:0] req_pixel,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [g2em_pkg::PIXEL_W-1:0] rsp_edge_magnitude,
   output logic                              rsp_row_end,
   output logic                              rsp_frame_end,
   input  wire logic                         csr_write_enable,
   input  wire logic                         csr_index,
   input  wire logic [g2em_pkg::DIM_W-1:0]   csr_write_data
);
   import g2em_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CMP_W = ((COL_W + 1) > (DIM_W + 1)) ? (COL_W + 1) : (DIM_W + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FETCH = 3'd1;
   localparam logic [2:0] ST_SQX   = 3'd2;
   localparam logic [2:0] ST_SQY   = 3'd3;
   localparam logic [2:0] ST_ROOT  = 3'd4;

   logic [2:0]                 state_ff, state_in;
   logic [DIM_W-1:0]           width_ff, width_in;
   logic [DIM_W-1:0]           height_ff, height_in;
   logic [COL_W-1:0]           col_ff, col_in;
   logic [ROW_W-1:0]           row_ff, row_in;
   logic [PIXEL_W-1:0]         left_ff, left_in;
   logic [PIXEL_W-1:0]         upper_left_ff, upper_left_in;
   logic [PIXEL_W-1:0]         pixel_ff, pixel_in;
   logic [COL_W-1:0]           wr_col_ff, wr_col_in;
   logic                       has_result_ff, has_result_in;
   logic                       last_col_ff, last_col_in;
   logic                       last_row_ff, last_row_in;
   logic signed [GRAD_W-1:0]   gx_ff, gx_in;
   logic signed [GRAD_W-1:0]   gy_ff, gy_in;
   logic [SQ_W-1:0]            sq_ff, sq_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]         rsp_mag_ff, rsp_mag_in;
   logic                       rsp_row_end_ff, rsp_row_end_in;
   logic                       rsp_frame_end_ff, rsp_frame_end_in;

   logic                       accept;
   logic                       out_free;
   logic [CMP_W-1:0]           width_raw;
   logic [CMP_W-1:0]           width_eff;
   logic [DIM_W-1:0]           height_eff;
   logic                       last_col;
   logic                       last_row;
   logic [PIXEL_W-1:0]         upper;
   logic [PIXEL_W:0]           sum_be, sum_ad, sum_de, sum_ab;
   logic signed [GRAD_W-1:0]   mul_op;
   logic signed [PROD_W-1:0]   product;
   logic [SQ_W-1:0]            square;
   logic                       root_start;
   logic [SQ_W-1:0]            root_operand;
   logic                       root_done;
   logic [ROOT_W-1:0]          root;
   logic [PIXEL_W-1:0]         magnitude;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Clamp the image dimensions to their legal ranges.
   always_comb begin
      width_raw = CMP_W'(width_ff);
      if (width_raw < CMP_W'(2)) begin
         width_eff = CMP_W'(2);
      end else if (width_raw > CMP_W'(MAX_WIDTH)) begin
         width_eff = CMP_W'(MAX_WIDTH);
      end else begin
         width_eff = width_raw;
      end
      if (height_ff < DIM_W'(2)) begin
         height_eff = DIM_W'(2);
      end else if (height_ff > DIM_W'(MAX_HEIGHT)) begin
         height_eff = DIM_W'(MAX_HEIGHT);
      end else begin
         height_eff = height_ff;
      end
   end

   assign last_col = (CMP_W'(col_ff) + CMP_W'(1)) >= width_eff;
   assign last_row = ({1'b0, row_ff} + DIM_W'(1)) >= height_eff;

   // Line store holding the previous row.
   g2em_ram #(
      .DATA_W (PIXEL_W),
      .DEPTH  (MAX_WIDTH)
   ) u_line_store (
      .clock     (clock),
      .wr_enable (state_ff == ST_FETCH),
      .wr_addr   (wr_col_ff),
      .wr_data   (pixel_ff),
      .rd_enable (accept),
      .rd_addr   (col_ff),
      .rd_data   (upper)
   );

   // Window differences: a upper-left, b upper, d left, e new pixel.
   // They are captured in the fetch cycle, while the window registers still hold a and d.
   always_comb begin
      sum_be = {1'b0, upper} + {1'b0, pixel_ff};
      sum_ad = {1'b0, upper_left_ff} + {1'b0, left_ff};
      sum_de = {1'b0, left_ff} + {1'b0, pixel_ff};
      sum_ab = {1'b0, upper_left_ff} + {1'b0, upper};
      gx_in  = gx_ff;
      gy_in  = gy_ff;
      if (state_ff == ST_FETCH) begin
         gx_in = $signed({2'b00, sum_be}) - $signed({2'b00, sum_ad});
         gy_in = $signed({2'b00, sum_de}) - $signed({2'b00, sum_ab});
      end
   end

   // Shared squarer: gx in the SQX state, gy in the SQY state.
   assign mul_op       = (state_ff == ST_SQX) ? gx_ff : gy_ff;
   assign product      = mul_op * mul_op;
   assign square       = product[SQ_W-1:0];
   assign root_start   = (state_ff == ST_SQY);
   assign root_operand = sq_ff + square;

   g2em_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (root_start),
      .operand (root_operand),
      .done    (root_done),
      .root    (root)
   );

   assign magnitude = (root > ROOT_W'(SAT_LIMIT)) ? SAT_LIMIT : root[PIXEL_W-1:0];

   // Configuration writes.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_write_data;
            CSR_IMAGE_HEIGHT: height_in = csr_write_data;
            default:          width_in  = width_ff;
         endcase
      end
   end

   // Sequencer, raster counters and window registers.
   always_comb begin
      state_in         = state_ff;
      col_in           = col_ff;
      row_in           = row_ff;
      left_in          = left_ff;
      upper_left_in    = upper_left_ff;
      pixel_in         = pixel_ff;
      wr_col_in        = wr_col_ff;
      has_result_in    = has_result_ff;
      last_col_in      = last_col_ff;
      last_row_in      = last_row_ff;
      sq_in            = sq_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_mag_in       = rsp_mag_ff;
      rsp_row_end_in   = rsp_row_end_ff;
      rsp_frame_end_in = rsp_frame_end_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pixel_in      = req_pixel;
               wr_col_in     = col_ff;
               has_result_in = (row_ff != '0) && (col_ff != '0);
               last_col_in   = last_col;
               last_row_in   = last_row;
               if (last_col) begin
                  col_in = '0;
                  row_in = last_row ? '0 : row_ff + ROW_W'(1);
               end else begin
                  col_in = col_ff + COL_W'(1);
               end
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            upper_left_in = upper;
            left_in       = pixel_ff;
            state_in      = has_result_ff ? ST_SQX : ST_IDLE;
         end
         ST_SQX: begin
            sq_in    = square;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_done && out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_mag_in       = magnitude;
               rsp_row_end_in   = last_col_ff;
               rsp_frame_end_in = last_col_ff && last_row_ff;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         width_ff      <= WIDTH_RESET;
         height_ff     <= HEIGHT_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         left_ff       <= '0;
         upper_left_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         left_ff       <= left_in;
         upper_left_ff <= upper_left_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pixel_ff         <= pixel_in;
      wr_col_ff        <= wr_col_in;
      has_result_ff    <= has_result_in;
      last_col_ff      <= last_col_in;
      last_row_ff      <= last_row_in;
      gx_ff            <= gx_in;
      gy_ff            <= gy_in;
      sq_ff            <= sq_in;
      rsp_mag_ff       <= rsp_mag_in;
      rsp_row_end_ff   <= rsp_row_end_in;
      rsp_frame_end_ff <= rsp_frame_end_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_edge_magnitude = rsp_mag_ff;
   assign rsp_row_end        = rsp_row_end_ff;
   assign rsp_frame_end      = rsp_frame_end_ff;

   // An accepted request puts the block into its busy sequence, which stalls the input.
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("request accepted without entering the busy sequence");

   // A new result appears only out of the square root wait.
   a_result_from_root: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_ROOT)
      else $error("result raised outside the square root wait");

   // The column counter never leaves the line store.
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      accept |-> (CMP_W'(col_ff) < CMP_W'(MAX_WIDTH)))
      else $error("column counter beyond line store depth");

   // A frame end is always also a row end.
   a_frame_end_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end)
      else $error("frame end without row end");

endmodule
`default_nettype wire

>>> design/g2em_ram.sv
// Generic simple dual-port RAM with a registered read port.
`default_nettype none
module g2em_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_enable,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic                     rd_enable,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_enable) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_enable) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> design/g2em_isqrt.sv
// Iterative floor integer square root, one result bit per cycle.
`default_nettype none
module g2em_isqrt (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [g2em_pkg::SQ_W-1:0] operand,
   output logic                           done,
   output logic [g2em_pkg::ROOT_W-1:0]    root
);
   import g2em_pkg::*;

   logic [SQ_W-1:0] rem_ff, rem_in;
   logic [SQ_W-1:0] root_ff, root_in;
   logic [SQ_W-1:0] bit_ff, bit_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [SQ_W:0]   trial;

   // One step of the digit-by-digit root: try subtracting root plus the current bit.
   always_comb begin
      trial   = {1'b0, root_ff} + {1'b0, bit_ff};
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = operand;
         root_in = '0;
         bit_in  = {2'b01, {(SQ_W-2){1'b0}}};
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in  = rem_ff - trial[SQ_W-1:0];
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         // The lowest bit position is the final step.
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign done = done_ff;
   assign root = root_ff[ROOT_W-1:0];

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking stream testbench for the 2x2 gradient edge magnitude block.
module tb_top;
   import g2em_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 200_000;
   localparam int unsigned IDLE_PERCENT  = 18;
   localparam int unsigned SETTLE_CYCLES = 32;
   localparam int unsigned RESULT_WAIT   = 4000;
   localparam int unsigned LONG_HOLD     = 400;
   localparam int unsigned RANDOM_PIXELS = 380;
   localparam int unsigned REPORT_LINES  = 50;

   typedef struct packed {
      logic [PIXEL_W-1:0] magnitude;
      logic               row_end;
      logic               frame_end;
   } edge_result_type;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic [PIXEL_W-1:0] req_pixel        = '0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic [PIXEL_W-1:0] rsp_edge_magnitude;
   logic               rsp_row_end;
   logic               rsp_frame_end;
   logic               csr_write_enable = 1'b0;
   logic               csr_index        = CSR_IMAGE_WIDTH;
   logic [DIM_W-1:0]   csr_write_data   = '0;

   gradient_2x2_edge_magnitude dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pixel          (req_pixel),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_edge_magnitude (rsp_edge_magnitude),
      .rsp_row_end        (rsp_row_end),
      .rsp_frame_end      (rsp_frame_end),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #1 clock = ~clock;

   // Mirror of the block state: line store, window registers, raster position, registers.
   logic [PIXEL_W-1:0] line_store [MAX_WIDTH_DEFAULT];
   logic [PIXEL_W-1:0] left_pixel_q   = '0;
   logic [PIXEL_W-1:0] upper_left_q   = '0;
   int unsigned        col_pos        = 0;
   int unsigned        row_pos        = 0;
   int unsigned        store_span     = 0;
   logic [DIM_W-1:0]   width_reg      = WIDTH_RESET;
   logic [DIM_W-1:0]   height_reg     = HEIGHT_RESET;

   edge_result_type    expected_edges [$];
   logic [PIXEL_W-1:0] pending_pixels [$];

   int unsigned queued_count   = 0;
   int unsigned accepted_count = 0;
   int unsigned edges_checked  = 0;
   int unsigned frames_seen    = 0;
   int unsigned csr_writes     = 0;
   int unsigned error_count    = 0;
   int unsigned cycle_count    = 0;
   int unsigned idle_pct       = IDLE_PERCENT;
   int unsigned hold_requests  = 0;
   int unsigned hold_served    = 0;
   int unsigned hold_left      = 0;
   logic        req_taken_ff   = 1'b0;

   function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return v;
   endfunction

   // Bitwise floor square root, one result bit per pass from the top.
   function automatic int unsigned floor_root(int unsigned sq);
      int unsigned root;
      int unsigned trial;
      root = 0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         trial = root | (1 << b);
         if (trial * trial <= sq) root = trial;
      end
      return root;
   endfunction

   // Advance the mirror by one pixel and queue the edge result it completes, if any.
   task automatic predict_edge(logic [PIXEL_W-1:0] lower_right);
      int unsigned        w, h, mag;
      int                 a, b, d, e, gx, gy;
      logic [PIXEL_W-1:0] upper;
      logic               last_col, last_row;
      edge_result_type    r;
      w        = clamp_dim(width_reg, MAX_WIDTH_DEFAULT);
      h        = clamp_dim(height_reg, MAX_HEIGHT);
      upper    = line_store[col_pos];
      last_col = (col_pos + 1 >= w);
      last_row = (row_pos + 1 >= h);
      if (row_pos >= 1 && col_pos >= 1) begin
         a  = int'(upper_left_q);
         b  = int'(upper);
         d  = int'(left_pixel_q);
         e  = int'(lower_right);
         gx = (b + e) - (a + d);
         gy = (d + e) - (a + b);
         mag = floor_root(gx * gx + gy * gy);
         if (mag > SAT_LIMIT) mag = SAT_LIMIT;
         r.magnitude = PIXEL_W'(mag);
         r.row_end   = last_col;
         r.frame_end = last_col && last_row;
         expected_edges.push_back(r);
      end
      upper_left_q        = upper;
      left_pixel_q        = lower_right;
      line_store[col_pos] = lower_right;
      if (col_pos + 1 > store_span) store_span = col_pos + 1;
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      if (error_count <= REPORT_LINES)
         $display("MISMATCH cycle %0d: %s: got %0d, expected %0d", cycle_count, what, got, want);
   endtask

   task automatic check_edge();
      edge_result_type want;
      if (expected_edges.size() == 0) begin
         report_mismatch("edge result with no request to match", rsp_edge_magnitude, 0);
         return;
      end
      want = expected_edges.pop_front();
      edges_checked++;
      if (rsp_edge_magnitude !== want.magnitude)
         report_mismatch("edge_magnitude", rsp_edge_magnitude, want.magnitude);
      if (rsp_row_end !== want.row_end)
         report_mismatch("row_end", rsp_row_end, want.row_end);
      if (rsp_frame_end !== want.frame_end)
         report_mismatch("frame_end", rsp_frame_end, want.frame_end);
      if (want.frame_end) frames_seen++;
   endtask

   // Monitor and predictor: everything is sampled at the rising edge.
   always @(posedge clock) begin
      cycle_count++;
      req_taken_ff <= req_valid && !req_stall;
      if (reset) begin
         width_reg    = WIDTH_RESET;
         height_reg   = HEIGHT_RESET;
         col_pos      = 0;
         row_pos      = 0;
         left_pixel_q = '0;
         upper_left_q = '0;
      end else begin
         if (rsp_valid && !rsp_stall) check_edge();
         if (req_valid && !req_stall) begin
            predict_edge(req_pixel);
            accepted_count++;
         end
         if (csr_write_enable) begin
            if (csr_index == CSR_IMAGE_WIDTH) width_reg = csr_write_data;
            else height_reg = csr_write_data;
            csr_writes++;
         end
      end
   end

   // Request driver: a new pixel is offered only once the previous one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken_ff) begin
         if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            req_valid <= 1'b1;
            req_pixel <= pending_pixels.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls, plus long hold-offs on request from the stimulus.
   always @(negedge clock) begin
      if (hold_left == 0 && hold_served != hold_requests) begin
         hold_served++;
         hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < idle_pct);
      end
   end

   // Pixel mix: dark and bright extremes, a flat band for mid-range magnitudes, noise.
   function automatic logic [PIXEL_W-1:0] random_pixel();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return PIXEL_W'(108 + $urandom_range(0, 40));
         default: return PIXEL_W'($urandom);
      endcase
   endfunction

   function automatic int unsigned pick_width();
      case ($urandom_range(0, 9))
         0:       return $urandom_range(0, 1);
         1:       return $urandom_range(11, 40);
         default: return $urandom_range(2, 10);
      endcase
   endfunction

   // Pixels still needed to close the current frame; valid only when drained.
   function automatic int unsigned pixels_to_frame_end();
      int unsigned w, h, row_left, rows_after;
      w          = clamp_dim(width_reg, MAX_WIDTH_DEFAULT);
      h          = clamp_dim(height_reg, MAX_HEIGHT);
      row_left   = (col_pos + 1 >= w) ? 1 : w - col_pos;
      rows_after = (row_pos + 1 >= h) ? 0 : h - row_pos - 1;
      return row_left + rows_after * w;
   endfunction

   // A new width must never make the next reads hit line store columns never written.
   function automatic bit width_write_safe(int unsigned v);
      return (row_pos == 0) || (clamp_dim(DIM_W'(v), MAX_WIDTH_DEFAULT) <= store_span);
   endfunction

   task automatic offer_pixel(logic [PIXEL_W-1:0] p);
      pending_pixels.push_back(p);
      queued_count++;
   endtask

   task automatic queue_pixels(int unsigned n);
      repeat (n) offer_pixel(random_pixel());
   endtask

   task automatic queue_window(logic [PIXEL_W-1:0] a, logic [PIXEL_W-1:0] b,
                               logic [PIXEL_W-1:0] d, logic [PIXEL_W-1:0] e);
      offer_pixel(a);
      offer_pixel(b);
      offer_pixel(d);
      offer_pixel(e);
   endtask

   // Wait until every request is taken and every edge result is back, then let the
   // block finish any pixel that produces no result.
   task automatic settle();
      int unsigned waited;
      waited = 0;
      while (accepted_count != queued_count) @(negedge clock);
      while (expected_edges.size() != 0 && waited < RESULT_WAIT) begin
         @(negedge clock);
         waited++;
      end
      if (expected_edges.size() != 0) begin
         report_mismatch("edge results never delivered", 0, expected_edges.size());
         expected_edges.delete();
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic idx, int unsigned value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= DIM_W'(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles with %0d edge results outstanding",
               cycle_count, expected_edges.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      int unsigned random_queued, frame_index, frame_pixels, split, w_pick, h_pick;
      bit          force_both;
      random_queued = 0;
      frame_index   = 0;
      reset <= 1'b1;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Reset dimensions: twenty pixels into the first 640-pixel row.
      queue_pixels(20);
      settle();
      // Shrink both dimensions mid-row so the next pixel closes the first row.
      write_register(CSR_IMAGE_HEIGHT, 2);
      write_register(CSR_IMAGE_WIDTH, 4);
      queue_pixels(pixels_to_frame_end());
      settle();

      // Dimensions below two act as two; single-window frames with chosen corners.
      write_register(CSR_IMAGE_WIDTH, 1);
      write_register(CSR_IMAGE_HEIGHT, 0);
      queue_window(8'd0, 8'd255, 8'd0, 8'd255);    // largest column difference
      queue_window(8'd255, 8'd0, 8'd0, 8'd0);      // both differences most negative
      settle();
      write_register(CSR_IMAGE_WIDTH, 0);
      write_register(CSR_IMAGE_HEIGHT, 1);
      queue_window(8'd0, 8'd0, 8'd0, 8'd181);      // root at the limit
      queue_window(8'd0, 8'd0, 8'd0, 8'd182);      // root above the limit
      settle();
      write_register(CSR_IMAGE_WIDTH, 2);
      write_register(CSR_IMAGE_HEIGHT, 2);
      queue_window(8'd10, 8'd13, 8'd14, 8'd17);    // exact root of 6 and 8
      queue_window(8'd0, 8'd0, 8'd0, 8'd180);
      queue_window(8'd0, 8'd0, 8'd0, 8'd1);
      queue_window(8'd255, 8'd255, 8'd255, 8'd255); // flat window
      settle();

      // Width above the line store depth acts as the depth; then shrink it mid-row.
      write_register(CSR_IMAGE_WIDTH, 13'h1FFF);
      write_register(CSR_IMAGE_HEIGHT, 1);
      queue_pixels(10);
      settle();
      write_register(CSR_IMAGE_WIDTH, 4);
      queue_pixels(pixels_to_frame_end());
      settle();

      // Height above the limit acts as the limit; the sender pauses mid-frame.
      write_register(CSR_IMAGE_WIDTH, 2);
      write_register(CSR_IMAGE_HEIGHT, 13'h1FFF);
      queue_pixels(40);
      settle();
      write_register(CSR_IMAGE_HEIGHT, 2);
      queue_pixels(pixels_to_frame_end());
      settle();

      // Random frames, mostly small, some back to back, some reconfigured mid-frame.
      while (random_queued < RANDOM_PIXELS) begin
         frame_index++;
         idle_pct   = (frame_index >= 6 && frame_index <= 10) ? 0 : IDLE_PERCENT;
         force_both = (frame_index == 1 || frame_index == 3);
         if (force_both || $urandom_range(0, 2) != 0) begin
            settle();
            w_pick = pick_width();
            h_pick = $urandom_range(0, 6);
            if (frame_index == 3) begin
               w_pick = 8;
               h_pick = 6;
            end
            if (force_both || $urandom_range(0, 3) != 0)
               write_register(CSR_IMAGE_WIDTH, w_pick);
            if (force_both || $urandom_range(0, 3) != 0)
               write_register(CSR_IMAGE_HEIGHT, h_pick);
            // Hold the results back long enough for the block to stall its input.
            if (frame_index == 3) hold_requests++;
         end
         frame_pixels = clamp_dim(width_reg, MAX_WIDTH_DEFAULT)
                        * clamp_dim(height_reg, MAX_HEIGHT);
         if (frame_pixels > 2 && $urandom_range(0, 3) == 0) begin
            split = $urandom_range(1, frame_pixels - 1);
            queue_pixels(split);
            random_queued += split;
            settle();
            w_pick = $urandom_range(0, 12);
            if ($urandom_range(0, 1) == 0 && width_write_safe(w_pick))
               write_register(CSR_IMAGE_WIDTH, w_pick);
            else
               write_register(CSR_IMAGE_HEIGHT, $urandom_range(0, 7));
            frame_pixels = pixels_to_frame_end();
         end
         queue_pixels(frame_pixels);
         random_queued += frame_pixels;
      end

      settle();
      $display("Checked %0d edge results from %0d pixel requests over %0d frames.",
               edges_checked, accepted_count, frames_seen);
      $display("Made %0d register writes: clamped and maximum sizes, mid-frame changes, %s",
               csr_writes, "a long output hold-off and random idling on both sides.");
      if (error_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
